/* hdl/bone_direction_frame_core_assert.svh */
// assertion macros for the bone direction frame core
// expects clk and rst_n in the scope of the including module
`ifndef BONE_DIRECTION_FRAME_CORE_ASSERT_SVH
`define BONE_DIRECTION_FRAME_CORE_ASSERT_SVH

`ifndef SYNTH
`define BDF_ASSERT_IMPLIES(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("bdf check failed");
`define BDF_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("bdf check failed");
`else
`define BDF_ASSERT_IMPLIES(lbl, ant, con)
`define BDF_ASSERT_NEXT(lbl, ant, con)
`endif

`endif

/* hdl/bdf_pkg.sv */
// shared widths, stage types and arithmetic steps for the bone direction frame core
// no dependencies
package bdf_pkg;

  localparam int COORD_W  = 32;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int MAG_W    = COORD_W + 1;
  localparam int NORM_TOP = 47;
  localparam int SMAG_W   = (MAG_W > NORM_TOP + 1) ? MAG_W : NORM_TOP + 1;
  localparam int SH_W     = $clog2(NORM_TOP + 1);
  localparam int MSB_W    = $clog2(MAG_W);
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int WSUM_W   = 2 * SMAG_W + 2;
  localparam int ROOT_W   = WSUM_W / 2;
  localparam int SR_W     = WSUM_W + 1;
  localparam int FRAC_W   = 14;
  localparam int AX_W     = 16;
  localparam int QW       = FRAC_W + 2;
  localparam int DIV_W    = ROOT_W + QW + 1;
  localparam int LEN_W    = 33;
  localparam int EPS_Q16  = 7;
  localparam int LXZ_RATIO = 10000;
  localparam int RATIO_W  = ROOT_W + 14;
  localparam int PROD_W   = 2 * AX_W;

  localparam logic [AX_W-1:0] ONE_Q14 = AX_W'(1 << FRAC_W);

  // square root lanes
  localparam int SQ_LEN  = 0;
  localparam int SQ_LXZ  = 1;
  localparam int SQ_BLEN = 2;
  // divider lanes
  localparam int DV_X  = 0;
  localparam int DV_Y  = 1;
  localparam int DV_Z  = 2;
  localparam int DV_SX = 3;
  localparam int DV_SZ = 4;

  typedef struct packed {
    logic [2:0][SR_W-1:0]   rem;
    logic [2:0][ROOT_W-1:0] root;
    logic [2:0][SMAG_W-1:0] mag;
    logic [2:0]             neg;
  } sq_stage_t;

  typedef struct packed {
    logic [4:0][DIV_W-1:0] rem;
    logic [4:0][QW-1:0]    quo;
    logic [4:0]            neg;
    logic [ROOT_W-1:0]     len;
    logic [ROOT_W-1:0]     lxz;
    logic                  degen;
    logic [LEN_W-1:0]      blen;
  } dv_stage_t;

  // one result bit of the three square roots
  function automatic sq_stage_t sqrt_step(input sq_stage_t cur, input int b);
    sq_stage_t nxt;
    logic [SR_W-1:0] trial;
    nxt = cur;
    for (int i = 0; i < 3; i++) begin
      trial = (SR_W'(cur.root[i]) << (b + 1)) + (SR_W'(1) << (2 * b));
      if (cur.rem[i] >= trial) begin
        nxt.rem[i]  = cur.rem[i] - trial;
        nxt.root[i] = cur.root[i] | (ROOT_W'(1) << b);
      end
    end
    return nxt;
  endfunction

  // one quotient bit of the five restoring dividers
  function automatic dv_stage_t div_step(input dv_stage_t cur, input int k);
    dv_stage_t nxt;
    logic [DIV_W-1:0] t;
    nxt = cur;
    for (int i = 0; i < 5; i++) begin
      t = DIV_W'((i < 3) ? cur.len : cur.lxz) << k;
      if (cur.rem[i] >= t) begin
        nxt.rem[i] = cur.rem[i] - t;
        nxt.quo[i] = cur.quo[i] | (QW'(1) << k);
      end
    end
    return nxt;
  endfunction

  function automatic logic [AX_W-1:0] to_axis(input logic neg, input logic [QW-1:0] q);
    logic [AX_W-1:0] m;
    m = (q > QW'(ONE_Q14)) ? ONE_Q14 : AX_W'(q);
    return neg ? AX_W'(-m) : m;
  endfunction

  // q2.28 product back to q1.14, round half away from zero
  function automatic logic [AX_W-1:0] q28_to_q14(input logic signed [PROD_W:0] p);
    logic [PROD_W:0] mag;
    logic [PROD_W:0] q;
    logic [AX_W-1:0] m;
    mag = p[PROD_W] ? (PROD_W+1)'(-p) : (PROD_W+1)'(p);
    q = (mag + (PROD_W+1)'(1 << (FRAC_W - 1))) >> FRAC_W;
    m = (q > (PROD_W+1)'(ONE_Q14)) ? ONE_Q14 : AX_W'(q);
    return p[PROD_W] ? AX_W'(-m) : m;
  endfunction

endpackage

/* hdl/bone_direction_frame_core.sv */
// bone direction frame core: look-at basis and length of one bone per transaction
// depends on bdf_pkg and bone_direction_frame_core_assert.svh
`include "bone_direction_frame_core_assert.svh"

// Takes one bone (start and end, signed Q16.16) per cycle and returns its length
// (Q17.16, saturating) and the side, up and direction axes in Q1.14. The pipeline
// is 73 register stages deep: a 49-step square root chain (three roots side by
// side) followed by a 16-step restoring divider (five quotients side by side) set
// most of it. A new transaction is taken every cycle; when a finished result is
// held by out_stall the whole pipeline freezes and in_stall rises.
module bone_direction_frame_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [bdf_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [bdf_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [bdf_pkg::COORD_W-1:0] in_start_z,
  input  logic signed [bdf_pkg::COORD_W-1:0] in_end_x,
  input  logic signed [bdf_pkg::COORD_W-1:0] in_end_y,
  input  logic signed [bdf_pkg::COORD_W-1:0] in_end_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [bdf_pkg::AX_W-1:0]    out_side_x,
  output logic signed [bdf_pkg::AX_W-1:0]    out_side_y,
  output logic signed [bdf_pkg::AX_W-1:0]    out_side_z,
  output logic signed [bdf_pkg::AX_W-1:0]    out_up_x,
  output logic signed [bdf_pkg::AX_W-1:0]    out_up_y,
  output logic signed [bdf_pkg::AX_W-1:0]    out_up_z,
  output logic signed [bdf_pkg::AX_W-1:0]    out_dir_x,
  output logic signed [bdf_pkg::AX_W-1:0]    out_dir_y,
  output logic signed [bdf_pkg::AX_W-1:0]    out_dir_z,
  output logic        [bdf_pkg::LEN_W-1:0]   out_bone_len
);
  import bdf_pkg::*;

  logic adv;

  // stage 1: difference vector
  logic signed [COORD_W-1:0] beg_c [3];
  logic signed [COORD_W-1:0] fin_c [3];
  logic signed [DIFF_W-1:0]  diff_c [3];
  logic [MAG_W-1:0] mag1_nxt [3];
  logic [2:0]       neg1_nxt;
  logic [MAG_W-1:0] mag1_r [3];
  logic [2:0]       neg1_r;
  logic             v1_r;

  // stage 2: squares and normalizing shift
  logic [MAG_W-1:0] max_c;
  logic [MSB_W-1:0] msb_c;
  logic [SH_W-1:0]  sh2_nxt;
  logic [SQ_W-1:0]  sq2_r [3];
  logic [SH_W-1:0]  sh2_r;
  logic [MAG_W-1:0] mag2_r [3];
  logic [2:0]       neg2_r;
  logic             v2_r;

  // stage 3: sums and scaled vector
  logic [SUM_W-1:0]  s3_nxt;
  logic [SUM_W-1:0]  sxz3_nxt;
  logic              short3_nxt;
  logic [SMAG_W-1:0] smag3_nxt [3];
  logic [SUM_W-1:0]  s3_r;
  logic [SUM_W-1:0]  sxz3_r;
  logic              short3_r;
  logic [SH_W-1:0]   sh3_r;
  logic [SMAG_W-1:0] smag3_r [3];
  logic [2:0]        neg3_r;
  logic              v3_r;

  // square root chain
  sq_stage_t       sq0_nxt;
  sq_stage_t       sq_r [ROOT_W+1];
  logic [ROOT_W:0] vsq_r;

  // divider chain
  dv_stage_t       dv0_nxt;
  dv_stage_t       dv_r [QW+1];
  logic [QW:0]     vdv_r;

  // axes before the cross product
  logic [AX_W-1:0]  ax_dir_r [3];
  logic [AX_W-1:0]  ax_sx_r;
  logic [AX_W-1:0]  ax_sz_r;
  logic [LEN_W-1:0] ax_blen_r;
  logic             vax_r;

  // products
  logic signed [PROD_W-1:0] pa_r, pb_r, pc_r, pd_r;
  logic [AX_W-1:0]  pr_dir_r [3];
  logic [AX_W-1:0]  pr_sx_r;
  logic [AX_W-1:0]  pr_sz_r;
  logic [LEN_W-1:0] pr_blen_r;
  logic             vpr_r;

  // output register
  logic             out_valid_r;
  logic [AX_W-1:0]  out_side_x_r, out_side_z_r;
  logic [AX_W-1:0]  out_up_x_r, out_up_y_r, out_up_z_r;
  logic [AX_W-1:0]  out_dir_x_r, out_dir_y_r, out_dir_z_r;
  logic [LEN_W-1:0] out_len_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // ---------------- stage 1
  always_comb begin
    beg_c[0] = in_start_x;
    beg_c[1] = in_start_y;
    beg_c[2] = in_start_z;
    fin_c[0] = in_end_x;
    fin_c[1] = in_end_y;
    fin_c[2] = in_end_z;
    for (int i = 0; i < 3; i++) begin
      diff_c[i] = DIFF_W'(fin_c[i]) - DIFF_W'(beg_c[i]);
    end
    // zero z is replaced by the epsilon
    if (diff_c[2] == '0) begin
      diff_c[2] = DIFF_W'(EPS_Q16);
    end
    for (int i = 0; i < 3; i++) begin
      neg1_nxt[i] = diff_c[i][DIFF_W-1];
      mag1_nxt[i] = MAG_W'(neg1_nxt[i] ? -diff_c[i] : diff_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag1_r <= mag1_nxt;
      neg1_r <= neg1_nxt;
    end
  end

  // ---------------- stage 2
  always_comb begin
    max_c = mag1_r[0];
    if (mag1_r[1] > max_c) max_c = mag1_r[1];
    if (mag1_r[2] > max_c) max_c = mag1_r[2];
    msb_c = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (max_c[i]) msb_c = MSB_W'(i);
    end
    if (SMAG_W'(max_c) < (SMAG_W'(1) << NORM_TOP)) begin
      sh2_nxt = SH_W'(NORM_TOP) - SH_W'(msb_c);
    end else begin
      sh2_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq2_r[i] <= SQ_W'(mag1_r[i]) * SQ_W'(mag1_r[i]);
      end
      sh2_r  <= sh2_nxt;
      mag2_r <= mag1_r;
      neg2_r <= neg1_r;
    end
  end

  // ---------------- stage 3
  always_comb begin
    s3_nxt     = SUM_W'(sq2_r[0]) + SUM_W'(sq2_r[1]) + SUM_W'(sq2_r[2]);
    sxz3_nxt   = SUM_W'(sq2_r[0]) + SUM_W'(sq2_r[2]);
    short3_nxt = s3_nxt < SUM_W'(EPS_Q16 * EPS_Q16);
    for (int i = 0; i < 3; i++) begin
      smag3_nxt[i] = SMAG_W'(mag2_r[i]) << sh2_r;
    end
    // too short to have a direction: point along z
    if (short3_nxt) begin
      smag3_nxt[0] = '0;
      smag3_nxt[1] = '0;
      smag3_nxt[2] = SMAG_W'(1) << NORM_TOP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r     <= s3_nxt;
      sxz3_r   <= sxz3_nxt;
      short3_r <= short3_nxt;
      sh3_r    <= sh2_r;
      smag3_r  <= smag3_nxt;
      neg3_r   <= short3_nxt ? 3'b000 : neg2_r;
    end
  end

  // ---------------- stage 4: load root chain
  // sums of squares of the scaled vector are the raw sums shifted by twice the shift
  always_comb begin
    sq0_nxt = '0;
    if (short3_r) begin
      sq0_nxt.rem[SQ_LEN] = SR_W'(1) << (2 * NORM_TOP);
      sq0_nxt.rem[SQ_LXZ] = SR_W'(1) << (2 * NORM_TOP);
    end else begin
      sq0_nxt.rem[SQ_LEN] = SR_W'(s3_r) << {sh3_r, 1'b0};
      sq0_nxt.rem[SQ_LXZ] = SR_W'(sxz3_r) << {sh3_r, 1'b0};
    end
    sq0_nxt.rem[SQ_BLEN] = SR_W'(s3_r);
    for (int i = 0; i < 3; i++) begin
      sq0_nxt.mag[i] = smag3_r[i];
    end
    sq0_nxt.neg = neg3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsq_r[0] <= 1'b0;
    end else if (adv) begin
      vsq_r[0] <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0] <= sq0_nxt;
    end
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vsq_r[j+1] <= 1'b0;
      end else if (adv) begin
        vsq_r[j+1] <= vsq_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[j+1] <= sqrt_step(sq_r[j], ROOT_W - 1 - j);
      end
    end
  end

  // ---------------- divider load
  always_comb begin
    dv0_nxt     = '0;
    dv0_nxt.len = sq_r[ROOT_W].root[SQ_LEN];
    dv0_nxt.lxz = sq_r[ROOT_W].root[SQ_LXZ];
    if (|sq_r[ROOT_W].root[SQ_BLEN][ROOT_W-1:LEN_W]) begin
      dv0_nxt.blen = '1;
    end else begin
      dv0_nxt.blen = sq_r[ROOT_W].root[SQ_BLEN][LEN_W-1:0];
    end
    // side axis falls back to x when the xz shadow is tiny
    dv0_nxt.degen = (RATIO_W'(dv0_nxt.lxz) * RATIO_W'(LXZ_RATIO)) < RATIO_W'(dv0_nxt.len);
    for (int i = 0; i < 3; i++) begin
      dv0_nxt.rem[i] = (DIV_W'(sq_r[ROOT_W].mag[i]) << FRAC_W)
                     + DIV_W'(dv0_nxt.len >> 1);
      dv0_nxt.neg[i] = sq_r[ROOT_W].neg[i];
    end
    dv0_nxt.rem[DV_SX] = (DIV_W'(sq_r[ROOT_W].mag[2]) << FRAC_W) + DIV_W'(dv0_nxt.lxz >> 1);
    dv0_nxt.rem[DV_SZ] = (DIV_W'(sq_r[ROOT_W].mag[0]) << FRAC_W) + DIV_W'(dv0_nxt.lxz >> 1);
    dv0_nxt.neg[DV_SX] = sq_r[ROOT_W].neg[2];
    dv0_nxt.neg[DV_SZ] = !sq_r[ROOT_W].neg[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vdv_r[0] <= 1'b0;
    end else if (adv) begin
      vdv_r[0] <= vsq_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0] <= dv0_nxt;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vdv_r[j+1] <= 1'b0;
      end else if (adv) begin
        vdv_r[j+1] <= vdv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[j+1] <= div_step(dv_r[j], QW - 1 - j);
      end
    end
  end

  // ---------------- axes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vax_r <= 1'b0;
    end else if (adv) begin
      vax_r <= vdv_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_dir_r[0] <= to_axis(dv_r[QW].neg[DV_X], dv_r[QW].quo[DV_X]);
      ax_dir_r[1] <= to_axis(dv_r[QW].neg[DV_Y], dv_r[QW].quo[DV_Y]);
      ax_dir_r[2] <= to_axis(dv_r[QW].neg[DV_Z], dv_r[QW].quo[DV_Z]);
      if (dv_r[QW].degen) begin
        ax_sx_r <= ONE_Q14;
        ax_sz_r <= '0;
      end else begin
        ax_sx_r <= to_axis(dv_r[QW].neg[DV_SX], dv_r[QW].quo[DV_SX]);
        ax_sz_r <= to_axis(dv_r[QW].neg[DV_SZ], dv_r[QW].quo[DV_SZ]);
      end
      ax_blen_r <= dv_r[QW].blen;
    end
  end

  // ---------------- cross product terms
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpr_r <= 1'b0;
    end else if (adv) begin
      vpr_r <= vax_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r      <= $signed(ax_dir_r[1]) * $signed(ax_sz_r);
      pb_r      <= $signed(ax_dir_r[2]) * $signed(ax_sx_r);
      pc_r      <= $signed(ax_dir_r[0]) * $signed(ax_sz_r);
      pd_r      <= $signed(ax_dir_r[1]) * $signed(ax_sx_r);
      pr_dir_r  <= ax_dir_r;
      pr_sx_r   <= ax_sx_r;
      pr_sz_r   <= ax_sz_r;
      pr_blen_r <= ax_blen_r;
    end
  end

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vpr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_side_x_r <= pr_sx_r;
      out_side_z_r <= pr_sz_r;
      out_up_x_r   <= q28_to_q14((PROD_W+1)'(pa_r));
      out_up_y_r   <= q28_to_q14((PROD_W+1)'(pb_r) - (PROD_W+1)'(pc_r));
      out_up_z_r   <= q28_to_q14(-((PROD_W+1)'(pd_r)));
      out_dir_x_r  <= pr_dir_r[0];
      out_dir_y_r  <= pr_dir_r[1];
      out_dir_z_r  <= pr_dir_r[2];
      out_len_r    <= pr_blen_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_side_x   = out_side_x_r;
  assign out_side_y   = '0;
  assign out_side_z   = out_side_z_r;
  assign out_up_x     = out_up_x_r;
  assign out_up_y     = out_up_y_r;
  assign out_up_z     = out_up_z_r;
  assign out_dir_x    = out_dir_x_r;
  assign out_dir_y    = out_dir_y_r;
  assign out_dir_z    = out_dir_z_r;
  assign out_bone_len = out_len_r;

  `BDF_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v1_r)
  `BDF_ASSERT_NEXT(a_freeze_holds_roots, !adv, $stable(vsq_r) && $stable(vdv_r))
  `BDF_ASSERT_IMPLIES(a_dir_z_range, out_valid_r, out_dir_z <= $signed(ONE_Q14) && out_dir_z >= -$signed(ONE_Q14))

endmodule
